// ----- hw/rtl/sbc_pkg.sv -----
package sbc_pkg;

  // Classification result codes
  typedef logic [1:0] relation_t;

  localparam relation_t REL_DISJOINT   = 2'd0;
  localparam relation_t REL_INTERSECTS = 2'd1;
  localparam relation_t REL_CONTAINS   = 2'd2;

  // Configuration register indexes
  localparam int CFG_INDEX_BITS = 3;
  typedef logic [CFG_INDEX_BITS-1:0] cfg_index_t;

  localparam cfg_index_t REG_CENTER_X       = 3'd0;
  localparam cfg_index_t REG_CENTER_Y       = 3'd1;
  localparam cfg_index_t REG_CENTER_Z       = 3'd2;
  localparam cfg_index_t REG_RADIUS_SQUARED = 3'd3;

endpackage

// ----- hw/rtl/sbc_axis.sv -----
module sbc_axis #(
  parameter int COORD_BITS = 16
) (
  input  logic                         clk,
  input  logic                         en,
  input  logic signed [COORD_BITS-1:0] center,
  input  logic signed [COORD_BITS-1:0] lo,
  input  logic signed [COORD_BITS-1:0] hi,
  output logic [2*COORD_BITS+1:0]      elo,
  output logic [2*COORD_BITS+1:0]      ehi,
  output logic                         lo_neg,
  output logic                         hi_neg
);

  localparam int DIFF_BITS = COORD_BITS + 1;
  localparam int SQ_BITS   = 2 * COORD_BITS + 2;

  logic signed [DIFF_BITS-1:0] dlo;
  logic signed [DIFF_BITS-1:0] dhi;
  logic [DIFF_BITS-1:0]        alo;
  logic [DIFF_BITS-1:0]        ahi;
  logic [SQ_BITS-1:0]          elo_next;
  logic [SQ_BITS-1:0]          ehi_next;

  // centre to min face, max face to centre
  assign dlo = DIFF_BITS'(center) - DIFF_BITS'(lo);
  assign dhi = DIFF_BITS'(hi) - DIFF_BITS'(center);

  // magnitude fits: |d| <= 2^COORD_BITS
  assign alo = dlo[DIFF_BITS-1] ? DIFF_BITS'(-dlo) : DIFF_BITS'(dlo);
  assign ahi = dhi[DIFF_BITS-1] ? DIFF_BITS'(-dhi) : DIFF_BITS'(dhi);

  assign elo_next = SQ_BITS'(alo) * SQ_BITS'(alo);
  assign ehi_next = SQ_BITS'(ahi) * SQ_BITS'(ahi);

  always_ff @(posedge clk) begin
    if (en) begin
      elo    <= elo_next;
      ehi    <= ehi_next;
      lo_neg <= dlo[DIFF_BITS-1];
      hi_neg <= dhi[DIFF_BITS-1];
    end
  end

endmodule

// ----- hw/rtl/sbc_classify.sv -----
module sbc_classify #(
  parameter int COORD_BITS = 16
) (
  input  logic [2:0][2*COORD_BITS+1:0] elo,
  input  logic [2:0][2*COORD_BITS+1:0] ehi,
  input  logic [2:0]                   lo_neg,
  input  logic [2:0]                   hi_neg,
  input  logic [2*COORD_BITS+1:0]      radius_squared,
  output sbc_pkg::relation_t           relation
);
  import sbc_pkg::*;

  localparam int SQ_BITS = 2 * COORD_BITS + 2;

  logic [2:0][SQ_BITS-1:0] gap;
  logic [SQ_BITS-1:0]      dist_sum;
  logic [2:0]              fit_lo;
  logic [2:0]              fit_hi;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      if (lo_neg[i]) begin
        gap[i] = elo[i];
      end else if (hi_neg[i]) begin
        gap[i] = ehi[i];
      end else begin
        gap[i] = '0;
      end
      fit_lo[i] = (elo[i] <= radius_squared);
      fit_hi[i] = (ehi[i] <= radius_squared);
    end
  end

  // three squares of at most 2^(2*COORD_BITS) each: no overflow
  assign dist_sum = gap[0] + gap[1] + gap[2];

  always_comb begin
    if (dist_sum > radius_squared) begin
      relation = REL_DISJOINT;
    end else if (&{fit_lo, fit_hi}) begin
      relation = REL_CONTAINS;
    end else if (|{fit_lo, fit_hi}) begin
      relation = REL_INTERSECTS;
    end else begin
      relation = REL_DISJOINT;
    end
  end

endmodule

// ----- hw/rtl/sphere_box_containment.sv -----
// Sphere against axis-aligned box classifier. Each accepted word is one box
// (min and max corners, signed COORD_BITS-bit fixed point); each box yields
// exactly one relation word: disjoint, intersects or contains, in arrival
// order. The sphere (centre and squared radius) sits in four registers on the
// config port; write them only while no box is in flight. cfg_ready is always
// high and writes to indexes above radius_squared are dropped. Throughput is
// one box per clock while out_stall is low; each box passes through three
// register stages: an input register, a register after the per-axis squares
// (one 17x17-bit squarer per face at the default width), and the result
// register after the distance sum and face compares. in_stall follows
// out_stall combinationally only when every stage is full.
module sphere_box_containment #(
  parameter int COORD_BITS = 16
) (
  input  logic                         clk,
  input  logic                         rst,
  // config write channel
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  sbc_pkg::cfg_index_t          cfg_index,
  input  logic [2*COORD_BITS+1:0]      cfg_data,
  // box channel
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic signed [COORD_BITS-1:0] box_min_x,
  input  logic signed [COORD_BITS-1:0] box_min_y,
  input  logic signed [COORD_BITS-1:0] box_min_z,
  input  logic signed [COORD_BITS-1:0] box_max_x,
  input  logic signed [COORD_BITS-1:0] box_max_y,
  input  logic signed [COORD_BITS-1:0] box_max_z,
  // result channel
  output logic                         out_valid,
  input  logic                         out_stall,
  output sbc_pkg::relation_t           relation
);
  import sbc_pkg::*;

  localparam int SQ_BITS = 2 * COORD_BITS + 2;

  // sphere registers
  logic signed [2:0][COORD_BITS-1:0] center;
  logic [SQ_BITS-1:0]                radius_squared;

  // stage 1: registered box
  logic                              s1_valid;
  logic signed [2:0][COORD_BITS-1:0] s1_lo;
  logic signed [2:0][COORD_BITS-1:0] s1_hi;

  // stage 2: registered squares and gap signs
  logic                    s2_valid;
  logic [2:0][SQ_BITS-1:0] s2_elo;
  logic [2:0][SQ_BITS-1:0] s2_ehi;
  logic [2:0]              s2_lo_neg;
  logic [2:0]              s2_hi_neg;

  relation_t relation_next;

  logic out_take;
  logic s2_ready;
  logic s1_ready;
  logic in_take;
  logic s2_load;

  // a stage may load when empty or when its word moves on this cycle
  assign out_take = !out_valid || !out_stall;
  assign s2_ready = !s2_valid || out_take;
  assign s1_ready = !s1_valid || s2_ready;
  assign in_stall = !s1_ready;
  assign in_take  = in_valid && s1_ready;
  assign s2_load  = s1_valid && s2_ready;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      center         <= '0;
      radius_squared <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_CENTER_X:       center[0] <= cfg_data[COORD_BITS-1:0];
        REG_CENTER_Y:       center[1] <= cfg_data[COORD_BITS-1:0];
        REG_CENTER_Z:       center[2] <= cfg_data[COORD_BITS-1:0];
        REG_RADIUS_SQUARED: radius_squared <= cfg_data;
        default: ;
      endcase
    end
  end

  // valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      s2_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (s1_ready) s1_valid <= in_valid;
      if (s2_ready) s2_valid <= s1_valid;
      if (out_take) out_valid <= s2_valid;
    end
  end

  // payload, no reset
  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_lo <= {box_min_z, box_min_y, box_min_x};
      s1_hi <= {box_max_z, box_max_y, box_max_x};
    end
    if (s2_valid && out_take) begin
      relation <= relation_next;
    end
  end

  for (genvar a = 0; a < 3; a++) begin : g_axis
    sbc_axis #(
      .COORD_BITS(COORD_BITS)
    ) u_axis (
      .clk   (clk),
      .en    (s2_load),
      .center(center[a]),
      .lo    (s1_lo[a]),
      .hi    (s1_hi[a]),
      .elo   (s2_elo[a]),
      .ehi   (s2_ehi[a]),
      .lo_neg(s2_lo_neg[a]),
      .hi_neg(s2_hi_neg[a])
    );
  end

  sbc_classify #(
    .COORD_BITS(COORD_BITS)
  ) u_classify (
    .elo           (s2_elo),
    .ehi           (s2_ehi),
    .lo_neg        (s2_lo_neg),
    .hi_neg        (s2_hi_neg),
    .radius_squared(radius_squared),
    .relation      (relation_next)
  );

endmodule

// ----- verif/testbench.sv -----
`timescale 1ns / 100ps

module testbench;
  import sbc_pkg::*;

  localparam int CW = 16;           // coordinate width, matches the block default
  localparam int RW = 2 * CW + 2;   // squared-radius register width
  localparam longint CMAX = (longint'(1) << (CW - 1)) - 1;
  localparam longint CMIN = -(longint'(1) << (CW - 1));
  localparam int HOLD_CYCLES = 120; // long output hold-off, fills the pipe
  localparam int LIMIT = 200000;    // run ceiling in clock cycles

  typedef logic signed [CW-1:0] coord_t;

  // One box query: min and max corner per axis (x, y, z).
  typedef struct {
    coord_t lo[3];
    coord_t hi[3];
  } box_t;

  // Tracks the sphere registers and the relation words still owed by the block.
  class containment_board;
    coord_t ctr[3];
    logic [RW-1:0] rsq;
    relation_t relations_due[$];
    int unsigned mismatches;
    int unsigned checked;

    function new();
      ctr = '{0, 0, 0};
      rsq = '0;
      mismatches = 0;
      checked = 0;
    endfunction

    // Mirror of a config write; the centre takes only the low coordinate bits.
    function void write_reg(cfg_index_t idx, logic [RW-1:0] data);
      case (idx)
        REG_CENTER_X:       ctr[0] = data[CW-1:0];
        REG_CENTER_Y:       ctr[1] = data[CW-1:0];
        REG_CENTER_Z:       ctr[2] = data[CW-1:0];
        REG_RADIUS_SQUARED: rsq = data;
        default: ;
      endcase
    endfunction

    function relation_t classify(box_t b);
      longint c, dlo, dhi, dist_sum, r2;
      longint elo[3], ehi[3];
      bit all_fit, any_fit;
      dist_sum = 0;
      all_fit = 1'b1;
      any_fit = 1'b0;
      r2 = longint'(rsq);
      for (int i = 0; i < 3; i++) begin
        c = ctr[i];
        dlo = c - longint'(b.lo[i]);
        dhi = longint'(b.hi[i]) - c;
        elo[i] = dlo * dlo;
        ehi[i] = dhi * dhi;
        // min face first, so an inverted box still takes one gap only
        if (dlo < 0)
          dist_sum += elo[i];
        else if (dhi < 0)
          dist_sum += ehi[i];
      end
      if (dist_sum > r2)
        return REL_DISJOINT;
      for (int i = 0; i < 3; i++) begin
        all_fit = all_fit && (elo[i] <= r2) && (ehi[i] <= r2);
        any_fit = any_fit || (elo[i] <= r2) || (ehi[i] <= r2);
      end
      if (all_fit)
        return REL_CONTAINS;
      if (any_fit)
        return REL_INTERSECTS;
      return REL_DISJOINT;
    endfunction

    function void note_box(box_t b);
      relations_due.push_back(classify(b));
    endfunction

    function void check_relation(relation_t got);
      relation_t want;
      if (relations_due.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("relation %0d with no box outstanding", got);
        return;
      end
      want = relations_due.pop_front();
      if (got !== want) begin
        mismatches++;
        if (mismatches <= 10)
          $display("relation mismatch on box %0d: expected %0d, got %0d", checked, want, got);
      end
      checked++;
    endfunction

    function int outstanding();
      return relations_due.size();
    endfunction
  endclass

  // DUT ports; the inputs are all known from time zero
  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  cfg_index_t cfg_index = '0;
  logic [RW-1:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  coord_t box_min_x = '0;
  coord_t box_min_y = '0;
  coord_t box_min_z = '0;
  coord_t box_max_x = '0;
  coord_t box_max_y = '0;
  coord_t box_max_z = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  relation_t relation;

  containment_board board;

  // Stimulus shaping: current sphere as the sender sees it, and idle control.
  coord_t sph_ctr[3] = '{0, 0, 0};
  int unsigned sph_r = 0;
  logic idling = 1'b0;     // random bubbles on both sides when set
  logic hold_req = 1'b0;   // one-shot request for a long receiver hold-off
  int hold_left = 0;
  int stall_left = 0;
  int cycle_count = 0;

  sphere_box_containment #(.COORD_BITS(CW)) dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .box_min_x (box_min_x),
    .box_min_y (box_min_y),
    .box_min_z (box_min_z),
    .box_max_x (box_max_x),
    .box_max_y (box_max_y),
    .box_max_z (box_max_z),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .relation  (relation)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Receiver: checks every accepted relation word, then picks next cycle's stall.
  // All reads happen before this edge's updates land, so they see what the DUT saw.
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall)
        board.check_relation(relation);
      if (hold_req) begin
        hold_req <= 1'b0;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else if (stall_left > 0) begin
        out_stall <= 1'b1;
        stall_left--;
      end else if (idling && $urandom_range(0, 7) == 0) begin
        // start a stall burst of random length, this cycle included
        out_stall <= 1'b1;
        stall_left = $urandom_range(0, 14);
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // Watchdog
  initial begin
    while (cycle_count < LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("[FAIL] regression broken");
    $finish;
  end

  function automatic coord_t clamp_coord(longint v);
    if (v > CMAX) return coord_t'(CMAX);
    if (v < CMIN) return coord_t'(CMIN);
    return coord_t'(v);
  endfunction

  function automatic box_t make_box(coord_t lx, coord_t ly, coord_t lz,
                                    coord_t hx, coord_t hy, coord_t hz);
    box_t b;
    b.lo = '{lx, ly, lz};
    b.hi = '{hx, hy, hz};
    return b;
  endfunction

  // Boxes mostly around the current sphere so all three relations turn up;
  // a fifth land anywhere in the coordinate space, often inverted.
  function automatic box_t random_box();
    box_t b;
    longint span, lo, hi, t;
    int unsigned mode;
    mode = $urandom_range(0, 9);
    span = longint'(sph_r) + 4;
    for (int i = 0; i < 3; i++) begin
      if (mode < 2) begin
        b.lo[i] = coord_t'($urandom);
        b.hi[i] = coord_t'($urandom);
      end else begin
        if (mode < 5) begin
          // every face within the radius: candidates for contains
          lo = longint'(sph_ctr[i]) - longint'($urandom_range(0, sph_r));
          hi = longint'(sph_ctr[i]) + longint'($urandom_range(0, sph_r));
        end else begin
          lo = longint'(sph_ctr[i]) + longint'($urandom_range(0, 4 * span)) - 2 * span;
          hi = longint'(sph_ctr[i]) + longint'($urandom_range(0, 4 * span)) - 2 * span;
          // keep some inverted boxes
          if (lo > hi && $urandom_range(0, 5) != 0) begin
            t = lo;
            lo = hi;
            hi = t;
          end
        end
        b.lo[i] = clamp_coord(lo);
        b.hi[i] = clamp_coord(hi);
      end
    end
    return b;
  endfunction

  // Drives one box word and holds it until the block takes it.
  task automatic send_box(box_t b);
    in_valid <= 1'b1;
    box_min_x <= b.lo[0];
    box_min_y <= b.lo[1];
    box_min_z <= b.lo[2];
    box_max_x <= b.hi[0];
    box_max_y <= b.hi[1];
    box_max_z <= b.hi[2];
    do @(posedge clk); while (in_stall);
    board.note_box(b);
  endtask

  // Sender goes quiet until every owed relation word has been checked.
  task automatic drain();
    in_valid <= 1'b0;
    while (board.outstanding() != 0)
      @(posedge clk);
  endtask

  // One config write; leaves cfg_valid high so back-to-back writes need one update per step.
  task automatic put_reg(cfg_index_t idx, logic [RW-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    board.write_reg(idx, data);
  endtask

  // Loads the whole sphere. Centre writes carry junk above the coordinate
  // bits, and now and then a write to an unused index is slipped in.
  task automatic load_sphere(coord_t cx, coord_t cy, coord_t cz, logic [RW-1:0] rsq);
    if ($urandom_range(0, 1))
      put_reg(cfg_index_t'(REG_RADIUS_SQUARED + 1 + $urandom_range(0, 3)), RW'($urandom));
    put_reg(REG_CENTER_X, {(RW - CW)'($urandom), cx});
    put_reg(REG_CENTER_Y, {(RW - CW)'($urandom), cy});
    put_reg(REG_CENTER_Z, {(RW - CW)'($urandom), cz});
    put_reg(REG_RADIUS_SQUARED, rsq);
    if ($urandom_range(0, 1))
      put_reg(cfg_index_t'(REG_RADIUS_SQUARED + 1 + $urandom_range(0, 3)), '1);
    cfg_valid <= 1'b0;
    sph_ctr = '{cx, cy, cz};
  endtask

  initial begin
    logic [RW-1:0] rsq_v;
    coord_t cc[3];
    int unsigned k;
    board = new();
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // Registers still at reset: point sphere at the origin.
    send_box(make_box(0, 0, 0, 0, 0, 0));          // degenerate box on the centre
    send_box(make_box(0, 0, 0, 1, 0, 0));          // one face touches only
    send_box(make_box(1, 0, 0, 2, 0, 0));          // just off the centre
    drain();

    // Modest sphere, r = 100, centred off origin.
    load_sphere(100, -200, 300, RW'(10000));
    send_box(make_box(90, -210, 290, 110, -190, 310));        // well inside
    send_box(make_box(150, -210, 290, 250, -190, 310));       // straddles the surface
    send_box(make_box(200, -200, 300, 300, -200, 300));       // gap equals the radius
    send_box(make_box(201, -200, 300, 300, -200, 300));       // one unit too far
    send_box(make_box(-1000, -1000, -1000, 1000, 1000, 1000));// swallows the sphere
    send_box(make_box(200, -210, 290, 0, -190, 310));         // inverted, centre below min
    send_box(make_box(150, -210, 290, 50, -190, 310));        // inverted, centre between
    send_box(make_box(50, -210, 290, -50, -190, 310));        // inverted, centre above both
    send_box(make_box(100, -32768, 300, 100, 32767, 300));    // long thin box through centre
    drain();

    // Extreme centre, largest squared radius.
    load_sphere(-32768, 32767, 0, '1);
    send_box(make_box(-32768, -32768, -32768, 32767, 32767, 32767));
    send_box(make_box(32767, 32767, 32767, -32768, -32768, -32768));
    send_box(make_box(32767, -32768, -32768, 32767, -32768, -32768));
    send_box(make_box(-32768, 32767, 0, -32768, 32767, 0));
    drain();

    // Opposite extremes with zero radius.
    load_sphere(32767, -32768, -1, '0);
    send_box(make_box(32767, -32768, -1, 32767, -32768, -1));
    send_box(make_box(-32768, 32767, 0, -32768, 32767, 0));
    send_box(make_box(32766, -32768, -1, 32767, -32767, -1));
    drain();

    // Random phases: a fresh sphere each time. Phase 1 carries the long
    // receiver hold-off; phases 1 and 4 and the closing phase run with no bubbles.
    for (int p = 0; p < 9; p++) begin
      for (int i = 0; i < 3; i++) begin
        case ($urandom_range(0, 5))
          0: cc[i] = coord_t'(CMIN);
          1: cc[i] = coord_t'(CMAX);
          default: cc[i] = coord_t'($urandom);
        endcase
      end
      k = $urandom_range(0, 16);
      sph_r = $urandom_range(0, 1 << k);
      rsq_v = RW'(longint'(sph_r) * longint'(sph_r));
      if ($urandom_range(0, 1))
        rsq_v += RW'($urandom_range(0, 2 * sph_r));
      if (p == 3) begin
        rsq_v = '1;
        sph_r = 2 * 65535;
      end
      if (p == 6) begin
        rsq_v = '0;
        sph_r = 0;
      end
      load_sphere(cc[0], cc[1], cc[2], rsq_v);
      idling <= !(p == 1 || p == 4 || p == 8);
      if (p == 1)
        hold_req <= 1'b1;
      for (int n = 0; n < 70; n++) begin
        send_box(random_box());
        if (idling && $urandom_range(0, 7) == 0) begin
          in_valid <= 1'b0;
          repeat ($urandom_range(1, 15)) @(posedge clk);
        end
      end
      drain();
    end

    // Let the three-stage pipe settle before the verdict.
    repeat (8) @(posedge clk);
    if (board.mismatches == 0 && board.outstanding() == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

endmodule
